[rtl/core/host_port_address_parser_top_macros.svh]
// Assertion macros for the host/port address parser.
`ifndef HOST_PORT_ADDRESS_PARSER_TOP_MACROS_SVH
`define HOST_PORT_ADDRESS_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define HPAP_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define HPAP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[rtl/core/hpap_pkg.sv]
// Shared types and constants for the host/port address parser.
`timescale 1ns / 1ps
package hpap_pkg;

   localparam int COUNT_MAX_DEF = 255;

   localparam int PH_W = 2;
   localparam logic [PH_W-1:0] PH_HOST = 2'd0;
   localparam logic [PH_W-1:0] PH_PORT = 2'd1;
   localparam logic [PH_W-1:0] PH_SKIP = 2'd2;

   localparam logic [1:0] END_NUL   = 2'd0;
   localparam logic [1:0] END_SLASH = 2'd1;
   localparam logic [1:0] END_SPACE = 2'd2;
   localparam logic [1:0] END_QM    = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_QM    = 8'h3f;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_Z     = 8'h7a;

   localparam logic [15:0] PORT_MAX = 16'hffff;

   typedef struct packed {
      logic [PH_W-1:0] phase;
      logic            digit_seen;
      logic [15:0]     port_accum;
   } state_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  end_kind;
      logic [7:0]  host_start;
      logic [7:0]  host_length;
      logic        has_port;
      logic [15:0] port_value;
   } result_type;

endpackage

[rtl/core/hpap_step.sv]
// Per-byte parse step: classifies one byte and computes next state and result.
`timescale 1ns / 1ps
module hpap_step #(
   parameter int COUNT_MAX = hpap_pkg::COUNT_MAX_DEF
) (
   input  logic [7:0]                         char_byte,
   input  hpap_pkg::state_type                cur_state,
   input  logic [$clog2(COUNT_MAX+1)-1:0]     cur_space,
   input  logic [$clog2(COUNT_MAX+1)-1:0]     cur_host,
   output hpap_pkg::state_type                nxt_state,
   output logic [$clog2(COUNT_MAX+1)-1:0]     nxt_space,
   output logic [$clog2(COUNT_MAX+1)-1:0]     nxt_host,
   output logic                               emit,
   output hpap_pkg::result_type               result
);

   localparam int CNT_W = $clog2(COUNT_MAX+1);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNT_MAX);

   logic             is_digit;
   logic             is_host;
   logic             host_empty;
   logic             err;
   logic [1:0]       kind;
   logic [19:0]      port_sum;
   logic [15:0]      port_sat;
   logic [CNT_W-1:0] space_inc;
   logic [CNT_W-1:0] host_inc;
   logic [CNT_W+7:0] space_ext;
   logic [CNT_W+7:0] host_ext;

   assign is_digit   = (char_byte >= hpap_pkg::CH_0) && (char_byte <= hpap_pkg::CH_9);
   assign is_host    = ((char_byte >= hpap_pkg::CH_A) && (char_byte <= hpap_pkg::CH_Z)) ||
                       is_digit || (char_byte == hpap_pkg::CH_DOT);
   assign host_empty = (cur_host == '0);

   assign space_inc = (cur_space >= CNT_TOP) ? CNT_TOP : cur_space + CNT_W'(1);
   assign host_inc  = (cur_host >= CNT_TOP) ? CNT_TOP : cur_host + CNT_W'(1);

   // accum*10 as shift-add, then the digit
   assign port_sum = {1'b0, cur_state.port_accum, 3'b000} + {3'b000, cur_state.port_accum, 1'b0}
                     + {16'd0, char_byte[3:0] - hpap_pkg::CH_0[3:0]};
   assign port_sat = (port_sum[19:16] != 4'd0) ? hpap_pkg::PORT_MAX : port_sum[15:0];

   assign space_ext = {8'd0, cur_space};
   assign host_ext  = {8'd0, cur_host};

   always_comb begin
      nxt_state = cur_state;
      nxt_space = cur_space;
      nxt_host  = cur_host;
      emit      = 1'b0;
      err       = 1'b0;
      kind      = hpap_pkg::END_NUL;
      case (cur_state.phase)
         hpap_pkg::PH_HOST: begin
            if (char_byte == hpap_pkg::CH_NUL) begin
               emit = 1'b1;
               err  = host_empty;
               kind = hpap_pkg::END_NUL;
            end else if (char_byte == hpap_pkg::CH_SPACE) begin
               if (host_empty) begin
                  nxt_space = space_inc;
               end else begin
                  emit            = 1'b1;
                  kind            = hpap_pkg::END_SPACE;
                  nxt_state.phase = hpap_pkg::PH_SKIP;
               end
            end else if (is_host) begin
               nxt_host = host_inc;
            end else if (host_empty) begin
               emit = 1'b1;
               err  = 1'b1;
            end else if (char_byte == hpap_pkg::CH_SLASH) begin
               emit            = 1'b1;
               kind            = hpap_pkg::END_SLASH;
               nxt_state.phase = hpap_pkg::PH_SKIP;
            end else if (char_byte == hpap_pkg::CH_QM) begin
               emit            = 1'b1;
               kind            = hpap_pkg::END_QM;
               nxt_state.phase = hpap_pkg::PH_SKIP;
            end else if (char_byte == hpap_pkg::CH_COLON) begin
               nxt_state.phase = hpap_pkg::PH_PORT;
            end else begin
               emit = 1'b1;
               err  = 1'b1;
            end
         end
         hpap_pkg::PH_PORT: begin
            if (char_byte == hpap_pkg::CH_NUL) begin
               emit = 1'b1;
               kind = hpap_pkg::END_NUL;
            end else if (is_digit) begin
               nxt_state.port_accum = port_sat;
               nxt_state.digit_seen = 1'b1;
            end else if (!cur_state.digit_seen) begin
               emit = 1'b1;
               err  = 1'b1;
            end else if (char_byte == hpap_pkg::CH_SPACE) begin
               emit            = 1'b1;
               kind            = hpap_pkg::END_SPACE;
               nxt_state.phase = hpap_pkg::PH_SKIP;
            end else if (char_byte == hpap_pkg::CH_SLASH) begin
               emit            = 1'b1;
               kind            = hpap_pkg::END_SLASH;
               nxt_state.phase = hpap_pkg::PH_SKIP;
            end else if (char_byte == hpap_pkg::CH_QM) begin
               emit            = 1'b1;
               kind            = hpap_pkg::END_QM;
               nxt_state.phase = hpap_pkg::PH_SKIP;
            end else begin
               emit = 1'b1;
               err  = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (err) begin
         nxt_state.phase = hpap_pkg::PH_SKIP;
      end
      // end of string restarts parsing in every phase
      if (char_byte == hpap_pkg::CH_NUL) begin
         nxt_state.phase      = hpap_pkg::PH_HOST;
         nxt_state.digit_seen = 1'b0;
         nxt_state.port_accum = 16'd0;
         nxt_space            = '0;
         nxt_host             = '0;
      end
   end

   always_comb begin
      result = '0;
      result.status = err;
      if (!err) begin
         result.end_kind    = kind;
         result.host_start  = space_ext[7:0];
         result.host_length = host_ext[7:0];
         result.has_port    = cur_state.digit_seen;
         result.port_value  = cur_state.digit_seen ? cur_state.port_accum : 16'd0;
      end
   end

endmodule

[rtl/core/host_port_address_parser_top.sv]
// Usage notes:
// Host/port address parser. One string byte enters per word on the req_ channel
// (req_char_byte, byte 0 ends a string). At most one result word per string
// leaves on the rsp_ channel, at the byte that decides the outcome: status,
// end_kind, host_start, host_length, has_port, port_value. After an error or a
// terminator the remaining bytes up to the next 0 give no result.
// A byte taken into the byte register is parsed in the following cycle; its result
// is then registered in the result register unless a result held under rsp_stall blocks it.
// Throughput: one byte per cycle while req_stall is low; the parse state sits in one register loop
// (byte register -> step logic -> state and result registers).
// A byte that causes no result moves on even while rsp_stall holds a result.
// When a result is waiting under rsp_stall and the next byte would give another
// one, the byte register holds and req_stall rises until the result is taken.
// Reset (synchronous, active high) drops both valid flags and returns the
// parser to the host phase with all counters at zero.
`timescale 1ns / 1ps
`include "host_port_address_parser_top_macros.svh"
module host_port_address_parser_top #(
   parameter int COUNT_MAX = hpap_pkg::COUNT_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [1:0]  rsp_end_kind,
   output logic [7:0]  rsp_host_start,
   output logic [7:0]  rsp_host_length,
   output logic        rsp_has_port,
   output logic [15:0] rsp_port_value
);

   localparam int CNT_W = $clog2(COUNT_MAX+1);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_byte_ff;
   hpap_pkg::state_type  state_ff;
   hpap_pkg::state_type  state_in;
   logic [CNT_W-1:0]     space_ff;
   logic [CNT_W-1:0]     space_in;
   logic [CNT_W-1:0]     host_ff;
   logic [CNT_W-1:0]     host_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   hpap_pkg::result_type out_ff;
   hpap_pkg::result_type step_result;
   logic                 step_emit;
   logic                 advance;
   logic                 take_in;

   hpap_step #(
      .COUNT_MAX (COUNT_MAX)
   ) u_step (
      .char_byte (in_byte_ff),
      .cur_state (state_ff),
      .cur_space (space_ff),
      .cur_host  (host_ff),
      .nxt_state (state_in),
      .nxt_space (space_in),
      .nxt_host  (host_in),
      .emit      (step_emit),
      .result    (step_result)
   );

   assign advance   = in_valid_ff && (!step_emit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_in   = req_valid && !req_stall;

   assign in_valid_in  = take_in || (in_valid_ff && !advance);
   assign out_valid_in = (advance && step_emit) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: hpap_pkg::PH_HOST, digit_seen: 1'b0, port_accum: 16'd0};
         space_ff     <= '0;
         host_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
            space_ff <= space_in;
            host_ff  <= host_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_byte_ff <= req_char_byte;
      end
      if (advance && step_emit) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_end_kind    = out_ff.end_kind;
   assign rsp_host_start  = out_ff.host_start;
   assign rsp_host_length = out_ff.host_length;
   assign rsp_has_port    = out_ff.has_port;
   assign rsp_port_value  = out_ff.port_value;

   `HPAP_ASSERT_IMPL(a_no_overwrite, clock, reset,
      in_valid_ff && step_emit && out_valid_ff && rsp_stall, req_stall,
      "result would overwrite a stalled word")

   `HPAP_ASSERT_IMPL(a_err_clean, clock, reset, out_valid_ff && out_ff.status,
      out_ff.end_kind == hpap_pkg::END_NUL && out_ff.host_start == 8'd0 &&
      out_ff.host_length == 8'd0 && !out_ff.has_port && out_ff.port_value == 16'd0,
      "error word carries nonzero fields")

   `HPAP_ASSERT_IMPL(a_port_absent, clock, reset, out_valid_ff && !out_ff.has_port,
      out_ff.port_value == 16'd0, "port value without port digits")

   `HPAP_ASSERT_NEXT(a_string_end, clock, reset,
      advance && in_byte_ff == hpap_pkg::CH_NUL,
      state_ff.phase == hpap_pkg::PH_HOST && space_ff == '0 && host_ff == '0 &&
      !state_ff.digit_seen && state_ff.port_accum == 16'd0,
      "string end did not clear parse state")

endmodule
